// File: src/assert_macros.svh
// Concurrent assertion macros used by the haversine distance unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

// File: src/hdu_pkg.sv
// Types, constants and helpers for the haversine distance unit.
package hdu_pkg;

    localparam int ANGLE_FRAC_BITS   = 20;
    localparam int CORDIC_STAGES_DEF = 24;
    localparam int SQRT_STEPS        = 31;

    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int RAD_W  = 16;
    localparam int DIST_W = 34;
    localparam int XW     = 33;
    localparam int ZW     = 34;
    localparam int MW     = 31;
    localparam int RW     = 61;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd6371;
    localparam logic [XW-1:0]    CORDIC_GAIN  = 33'd652032874;
    localparam logic [30:0]      Q30_ONE      = 31'h4000_0000;
    localparam logic [31:0]      PI_Q30       = 32'd3373259426;
    localparam logic [26:0]      DEG_TO_RAD   = 27'd74961321;

    localparam logic [ZW-1:0] ATAN_Q30 [0:31] = '{
        34'd843314857, 34'd497837829, 34'd263043837, 34'd133525159, 34'd67021687,
        34'd33543516, 34'd16775851, 34'd8388437, 34'd4194283, 34'd2097149,
        34'd1048576, 34'd524288, 34'd262144, 34'd131072, 34'd65536, 34'd32768,
        34'd16384, 34'd8192, 34'd4096, 34'd2048, 34'd1024, 34'd512, 34'd256,
        34'd128, 34'd64, 34'd32, 34'd16, 34'd8, 34'd4, 34'd2, 34'd1, 34'd1
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [RW-1:0]         rem;
        logic [SQRT_STEPS-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic [MW-1:0] m;
        logic          neg_s;
        logic          neg_c;
    } t_fold;

    // reduce to one turn, fold to the first quadrant, requantize to Q24 degrees
    function automatic t_fold fn_fold(input logic signed [31:0] i_d, input int frac);
        logic signed [31:0] full;
        logic signed [31:0] half;
        logic signed [31:0] quar;
        logic signed [31:0] r;
        t_fold f;
        full = 32'sd360 <<< frac;
        half = 32'sd180 <<< frac;
        quar = 32'sd90 <<< frac;
        r = i_d;
        f.neg_s = 1'b0;
        f.neg_c = 1'b0;
        if (r > half) begin
            r = r - full;
        end else if (r <= -half) begin
            r = r + full;
        end
        if (r < 0) begin
            f.neg_s = 1'b1;
            r = -r;
        end
        if (r > quar) begin
            r = half - r;
            f.neg_c = 1'b1;
        end
        f.m = MW'(r << (24 - frac));
        return f;
    endfunction

endpackage

// File: src/hdu_if.sv
// Input and output channel interfaces of the haversine distance unit.
interface hdu_in_if;
    import hdu_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] first_latitude;
    logic signed [LON_W-1:0] first_longitude;
    logic signed [LAT_W-1:0] second_latitude;
    logic signed [LON_W-1:0] second_longitude;
    modport source(output valid, first_latitude, first_longitude, second_latitude,
                   second_longitude, input ready);
    modport sink(input valid, first_latitude, first_longitude, second_latitude,
                 second_longitude, output ready);
endinterface

interface hdu_out_if;
    import hdu_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    modport source(output valid, distance, input ready);
    modport sink(input valid, distance, output ready);
endinterface

// File: src/hdu_rot_cell.sv
// One CORDIC rotation stage: sine and cosine of an angle.
module hdu_rot_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  hdu_pkg::t_cordic i_d,
    output hdu_pkg::t_cordic o_q
);
    import hdu_pkg::*;

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    t_cordic              n_q;
    t_cordic              r_q;

    always_comb begin
        w_dx = $signed(i_d.y) >>> IDX;
        w_dy = $signed(i_d.x) >>> IDX;
        if (i_d.z >= 0) begin
            n_q.x = i_d.x - w_dx;
            n_q.y = i_d.y + w_dy;
            n_q.z = i_d.z - $signed(ATAN_Q30[IDX]);
        end else begin
            n_q.x = i_d.x + w_dx;
            n_q.y = i_d.y - w_dy;
            n_q.z = i_d.z + $signed(ATAN_Q30[IDX]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

// File: src/hdu_sqrt_cell.sv
// One digit step of a floor square root.
module hdu_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  hdu_pkg::t_sqrt i_d,
    output hdu_pkg::t_sqrt o_q
);
    import hdu_pkg::*;

    logic [RW+1:0] w_trial;
    t_sqrt         n_q;
    t_sqrt         r_q;

    always_comb begin
        w_trial = ((RW+2)'(i_d.root) << (BIT + 1)) + ((RW+2)'(1) << (2 * BIT));
        n_q = i_d;
        if ((RW+2)'(i_d.rem) >= w_trial) begin
            n_q.rem  = i_d.rem - RW'(w_trial);
            n_q.root = i_d.root | (SQRT_STEPS'(1) << BIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

// File: src/hdu_vec_cell.sv
// One CORDIC vectoring stage: angle of a vector.
module hdu_vec_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  hdu_pkg::t_cordic i_d,
    output hdu_pkg::t_cordic o_q
);
    import hdu_pkg::*;

    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    t_cordic              n_q;
    t_cordic              r_q;

    always_comb begin
        w_dx = $signed(i_d.y) >>> IDX;
        w_dy = $signed(i_d.x) >>> IDX;
        if (i_d.y > 0) begin
            n_q.x = i_d.x + w_dx;
            n_q.y = i_d.y - w_dy;
            n_q.z = i_d.z + $signed(ATAN_Q30[IDX]);
        end else begin
            n_q.x = i_d.x - w_dx;
            n_q.y = i_d.y + w_dy;
            n_q.z = i_d.z - $signed(ATAN_Q30[IDX]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule

// File: src/haversine_distance_unit.sv
// Haversine distance unit: takes one coordinate pair per cycle and returns the
// great-circle distance scaled by the radius register, 16 fraction bits. The
// datapath is a single pipeline of 42 + 2*CORDIC_STAGES stages: angle folding,
// a CORDIC rotation row, four Q30 multiplies over three stages, a 31-step
// square-root row, a CORDIC vectoring row and the radius multiply. A new item
// is taken every cycle; when a result is not taken at the output the whole
// pipeline holds. Write the radius only while idle.
`include "assert_macros.svh"

module haversine_distance_unit #(
    parameter int CORDIC_STAGES = hdu_pkg::CORDIC_STAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [hdu_pkg::RAD_W-1:0] i_cfg_wdata,
    hdu_in_if.sink                    i_req,
    hdu_out_if.source                 o_rsp
);
    import hdu_pkg::*;

    localparam int LAT = 11 + SQRT_STEPS + 2 * CORDIC_STAGES;

    logic [RAD_W-1:0] r_radius;
    logic [LAT-1:0]   r_vld;
    logic             w_en;

    logic signed [LAT_W:0]   r_dlat;
    logic signed [LON_W:0]   r_dlon;
    logic signed [LAT_W-1:0] r_lat1;
    logic signed [LAT_W-1:0] r_lat2;

    t_fold                n_f [4];
    logic [MW-1:0]        r_m [4];
    logic [2:0]           r_flg1;
    logic signed [ZW-1:0] r_z [4];
    logic [2:0]           r_flg2;
    logic [2:0]           r_flg_d [CORDIC_STAGES];
    t_cordic              w_rot [4][CORDIC_STAGES+1];

    logic signed [XW-1:0]   r_c1, r_c2, r_sdlat, r_sdlon;
    logic signed [2*XW-1:0] n_p1, n_q, n_p2, n_p3;
    logic signed [XW-1:0]   r_t1, r_t2, r_t3;
    logic signed [XW-1:0]   r_q1, r_q2, r_q3;
    logic signed [XW-1:0]   r_sdlon1, r_sdlon2;
    logic signed [XW:0]     r_asum;
    logic [30:0]            n_a;
    logic [30:0]            r_a;
    logic [30:0]            r_na;

    t_sqrt                w_sx [SQRT_STEPS+1];
    t_sqrt                w_sy [SQRT_STEPS+1];
    t_cordic              w_vec [CORDIC_STAGES+1];
    logic signed [ZW:0]   n_z2;
    logic [31:0]          r_c;
    logic [DIST_W-1:0]    r_dist;

    assign w_en        = !r_vld[LAT-1] || o_rsp.ready;
    assign i_req.ready = w_en;
    assign o_rsp.valid = r_vld[LAT-1];
    assign o_rsp.distance = r_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= RADIUS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_req.valid};
            end
        end
    end

    always_comb begin
        n_f[0] = fn_fold(32'(r_dlat), ANGLE_FRAC_BITS + 1);
        n_f[1] = fn_fold(32'(r_dlon), ANGLE_FRAC_BITS + 1);
        n_f[2] = fn_fold(32'(r_lat1), ANGLE_FRAC_BITS);
        n_f[3] = fn_fold(32'(r_lat2), ANGLE_FRAC_BITS);
    end

    // front end: differences, folding, degrees to radians
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dlat <= (LAT_W+1)'(i_req.second_latitude) - (LAT_W+1)'(i_req.first_latitude);
            r_dlon <= (LON_W+1)'(i_req.second_longitude)
                      - (LON_W+1)'(i_req.first_longitude);
            r_lat1 <= i_req.first_latitude;
            r_lat2 <= i_req.second_latitude;
            for (int i = 0; i < 4; i++) begin
                r_m[i] <= n_f[i].m;
                r_z[i] <= ZW'(((58'(r_m[i]) * 58'(DEG_TO_RAD)) + 58'(1 << 25)) >> 26);
            end
            r_flg1 <= {n_f[1].neg_s, n_f[3].neg_c, n_f[2].neg_c};
            r_flg2 <= r_flg1;
            r_flg_d[0] <= r_flg2;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                r_flg_d[k] <= r_flg_d[k-1];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        assign w_rot[l][0] = '{x: CORDIC_GAIN, y: '0, z: r_z[l]};
        for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
            hdu_rot_cell #(.IDX(k)) u_rot (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_d   (w_rot[l][k]),
                .o_q   (w_rot[l][k+1])
            );
        end
    end

    // a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2), clamped
    always_comb begin
        n_p1 = r_c1 * r_c2;
        n_q  = r_sdlat * r_sdlat;
        n_p2 = r_t1 * r_sdlon1;
        n_p3 = r_t2 * r_sdlon2;
        if (r_asum < 0) begin
            n_a = '0;
        end else if (r_asum > (XW+1)'(Q30_ONE)) begin
            n_a = Q30_ONE;
        end else begin
            n_a = r_asum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1 <= r_flg_d[CORDIC_STAGES-1][0] ? -w_rot[2][CORDIC_STAGES].x
                                                 : w_rot[2][CORDIC_STAGES].x;
            r_c2 <= r_flg_d[CORDIC_STAGES-1][1] ? -w_rot[3][CORDIC_STAGES].x
                                                 : w_rot[3][CORDIC_STAGES].x;
            r_sdlat  <= w_rot[0][CORDIC_STAGES].y;
            r_sdlon  <= r_flg_d[CORDIC_STAGES-1][2] ? -w_rot[1][CORDIC_STAGES].y
                                                     : w_rot[1][CORDIC_STAGES].y;
            r_t1     <= XW'(n_p1 >>> 30);
            r_q1     <= XW'(n_q >>> 30);
            r_sdlon1 <= r_sdlon;
            r_t2     <= XW'(n_p2 >>> 30);
            r_q2     <= r_q1;
            r_sdlon2 <= r_sdlon1;
            r_t3     <= XW'(n_p3 >>> 30);
            r_q3     <= r_q2;
            r_asum   <= (XW+1)'(r_q3) + (XW+1)'(r_t3);
            r_a      <= n_a;
            r_na     <= Q30_ONE - n_a;
        end
    end

    assign w_sx[0] = '{rem: {r_na, 30'b0}, root: '0};
    assign w_sy[0] = '{rem: {r_a, 30'b0}, root: '0};

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        hdu_sqrt_cell #(.BIT(SQRT_STEPS - 1 - j)) u_sqx (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sx[j]),
            .o_q   (w_sx[j+1])
        );
        hdu_sqrt_cell #(.BIT(SQRT_STEPS - 1 - j)) u_sqy (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sy[j]),
            .o_q   (w_sy[j+1])
        );
    end

    assign w_vec[0] = '{x: XW'(w_sx[SQRT_STEPS].root), y: XW'(w_sy[SQRT_STEPS].root), z: '0};

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
        hdu_vec_cell #(.IDX(k)) u_vec (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_vec[k]),
            .o_q   (w_vec[k+1])
        );
    end

    // c = 2 * angle clamped to [0, pi], then scale by the radius
    assign n_z2 = {w_vec[CORDIC_STAGES].z, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (n_z2 < 0) begin
                r_c <= '0;
            end else if (n_z2 > (ZW+1)'(PI_Q30)) begin
                r_c <= PI_Q30;
            end else begin
                r_c <= n_z2[31:0];
            end
            r_dist <= DIST_W'(((48'(r_radius) * 48'(r_c)) + 48'd8192) >> 14);
        end
    end

    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, !w_en |=> $stable(r_vld))
    `ASSERT_CLK(a_zero_radius, i_clk, i_rst_n, o_rsp.valid && (r_radius == '0) |-> (o_rsp.distance == '0))
    `ASSERT_CLK_NR(a_rst_clear, i_clk, !i_rst_n |=> !o_rsp.valid)
endmodule
